[rtl/core/tcw_pkg.sv]
// Package for the text console writer: screen geometry, character codes,
// step and micro-operation types, and the control store of the sequencer.
// Depends on nothing; used by rtl/core/text_console_writer.sv.
package tcw_pkg;

  // Screen geometry and derived widths.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int FILL_LAST  = CELL_COUNT - 1;
  localparam int COPY_LAST  = CELL_COUNT - COLUMNS - 1;

  // Character and attribute codes.
  localparam logic [7:0] NUL_CHAR       = 8'h00;
  localparam logic [7:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] RESET_ATTR     = 8'h07;

  // Configuration register map.
  localparam int         CFG_ADDR_W         = 3;
  localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

  // Item function selector.
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Sequencer steps (control store addresses).
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_NL,
    ST_BS_RD,
    ST_BS_WR,
    ST_RD,
    ST_RD_CAP,
    ST_CLR,
    ST_FILL,
    ST_SCR_PRIME,
    ST_SCR_COPY,
    ST_DONE
  } step_t;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_PUT,
    OP_NL,
    OP_BS_RD,
    OP_BS_WR,
    OP_RD,
    OP_RD_CAP,
    OP_HOME,
    OP_FILL,
    OP_FILL_INIT,
    OP_SCR_PRIME,
    OP_COPY,
    OP_DONE
  } op_t;

  // Sweep address counter control.
  typedef enum logic [1:0] {
    AS_HOLD,
    AS_ZERO,
    AS_INC
  } addr_sel_t;

  // Jump conditions. When a looping condition is not met the step repeats.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_DISPATCH,
    JC_SCROLL,
    JC_FILL_END,
    JC_COPY_END,
    JC_OUT_FREE
  } jump_t;

  // One control word.
  typedef struct packed {
    op_t       op;
    addr_sel_t asel;
    jump_t     jc;
    step_t     target;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_NOP, asel: AS_HOLD, jc: JC_NEXT, target: ST_IDLE};
    case (s)
      ST_INIT:      w = '{op: OP_FILL_INIT, asel: AS_INC,  jc: JC_FILL_END, target: ST_IDLE};
      ST_IDLE:      w = '{op: OP_IDLE,      asel: AS_ZERO, jc: JC_DISPATCH, target: ST_IDLE};
      ST_PUT:       w = '{op: OP_PUT,       asel: AS_HOLD, jc: JC_SCROLL,   target: ST_DONE};
      ST_NL:        w = '{op: OP_NL,        asel: AS_HOLD, jc: JC_SCROLL,   target: ST_DONE};
      ST_BS_RD:     w = '{op: OP_BS_RD,     asel: AS_HOLD, jc: JC_NEXT,     target: ST_BS_WR};
      ST_BS_WR:     w = '{op: OP_BS_WR,     asel: AS_HOLD, jc: JC_NEXT,     target: ST_DONE};
      ST_RD:        w = '{op: OP_RD,        asel: AS_HOLD, jc: JC_NEXT,     target: ST_RD_CAP};
      ST_RD_CAP:    w = '{op: OP_RD_CAP,    asel: AS_HOLD, jc: JC_NEXT,     target: ST_DONE};
      ST_CLR:       w = '{op: OP_HOME,      asel: AS_ZERO, jc: JC_NEXT,     target: ST_FILL};
      ST_FILL:      w = '{op: OP_FILL,      asel: AS_INC,  jc: JC_FILL_END, target: ST_DONE};
      ST_SCR_PRIME: w = '{op: OP_SCR_PRIME, asel: AS_ZERO, jc: JC_NEXT,     target: ST_SCR_COPY};
      ST_SCR_COPY:  w = '{op: OP_COPY,      asel: AS_INC,  jc: JC_COPY_END, target: ST_FILL};
      ST_DONE:      w = '{op: OP_DONE,      asel: AS_HOLD, jc: JC_OUT_FREE, target: ST_IDLE};
      default:      w = '{op: OP_NOP,       asel: AS_HOLD, jc: JC_NEXT,     target: ST_IDLE};
    endcase
    return w;
  endfunction

  // Linear screen address of a cell.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

[rtl/core/text_console_writer.sv]
// Text console writer: screen store, cursor and microcoded sequencer.
// Depends on rtl/core/tcw_pkg.sv (geometry, codes, control store).
//
//   Channel  Direction  Handshake                Payload
//   in_      input      in_tvalid / in_tready    func, ch, cell_row, cell_col
//   out_     output     out_tvalid / out_tready  cursor_row, cursor_col, cell_char, cell_attr
//   cfg_     input      APB write/read           text_attribute at byte address 0
//
// A clear homes the cursor and writes all 2000 cells, one cell write per cycle;
// an item that scrolls adds the row copy and bottom row blank through the single
// write port. After reset a clearing pass over all 2000 cells runs before the
// first item is taken; configuration writes are taken throughout. An item is
// accepted while the previous result still waits in the output register; its
// result waits in the sequencer until that register is free.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // func[1:0], ch[9:2], cell_row[14:10], cell_col[21:15], 0
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_row[4:0], cursor_col[11:5], cell_char[19:12],
                                  // cell_attr[27:20], 0
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // Sequencer and datapath state.
  tcw_pkg::step_t                 step_r, step_nxt;
  logic [tcw_pkg::ADDR_W-1:0]     a_r, a_nxt;
  logic [tcw_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [7:0]                     attr_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [31:0]                    out_data_r, out_data_nxt;

  // Latched item fields and read result.
  tcw_pkg::func_t                 func_r, func_nxt;
  logic [7:0]                     ch_r, ch_nxt;
  logic [4:0]                     rd_row_r, rd_row_nxt;
  logic [6:0]                     rd_col_r, rd_col_nxt;
  logic [15:0]                    cell_r, cell_nxt;

  // Screen memory.
  logic [15:0]                    screen_mem [tcw_pkg::CELL_COUNT];
  logic [15:0]                    rd_q;
  logic                           mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [15:0]                    mem_wdata;

  tcw_pkg::uword_t                uw;
  logic                           in_acc, out_free, rd_in_range, cfg_wr;
  tcw_pkg::func_t                 in_func;
  logic [7:0]                     in_ch;
  tcw_pkg::step_t                 disp_step;

  assign uw       = tcw_pkg::ucode(step_r);
  assign in_func  = tcw_pkg::func_t'(in_tdata[1:0]);
  assign in_ch    = in_tdata[9:2];
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign rd_in_range = (32'(rd_row_r) < tcw_pkg::ROWS) && (32'(rd_col_r) < tcw_pkg::COLUMNS);

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr && (cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE)) begin
      attr_r <= cfg_pwdata[7:0];
    end
  end

  // Dispatch map: first step of the routine for an accepted item.
  always_comb begin
    disp_step = tcw_pkg::ST_DONE;
    case (in_func)
      tcw_pkg::FUNC_PUT: begin
        if (in_ch == tcw_pkg::NUL_CHAR) begin
          disp_step = tcw_pkg::ST_DONE;
        end else if (in_ch == tcw_pkg::NEWLINE_CHAR) begin
          disp_step = tcw_pkg::ST_NL;
        end else if (in_ch == tcw_pkg::BACKSPACE_CHAR) begin
          disp_step = (col_r != '0) ? tcw_pkg::ST_BS_RD : tcw_pkg::ST_DONE;
        end else begin
          disp_step = tcw_pkg::ST_PUT;
        end
      end
      tcw_pkg::FUNC_READ:  disp_step = tcw_pkg::ST_RD;
      tcw_pkg::FUNC_CLEAR: disp_step = tcw_pkg::ST_CLR;
      default:             disp_step = tcw_pkg::ST_DONE;
    endcase
  end

  // Next step: jump condition of the current control word.
  always_comb begin
    step_nxt = step_r;
    case (uw.jc)
      tcw_pkg::JC_NEXT:     step_nxt = uw.target;
      tcw_pkg::JC_DISPATCH: step_nxt = in_acc ? disp_step : uw.target;
      tcw_pkg::JC_SCROLL: begin
        step_nxt = (32'(row_nxt) == tcw_pkg::ROWS) ? tcw_pkg::ST_SCR_PRIME : uw.target;
      end
      tcw_pkg::JC_FILL_END: begin
        step_nxt = (32'(a_r) == tcw_pkg::FILL_LAST) ? uw.target : step_r;
      end
      tcw_pkg::JC_COPY_END: begin
        step_nxt = (32'(a_r) == tcw_pkg::COPY_LAST) ? uw.target : step_r;
      end
      tcw_pkg::JC_OUT_FREE: step_nxt = out_free ? uw.target : step_r;
      default:              step_nxt = uw.target;
    endcase
  end

  // Datapath controls decoded from the control word.
  always_comb begin
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = a_r;
    mem_raddr     = a_r;
    mem_wdata     = {attr_r, tcw_pkg::BLANK_CHAR};
    row_nxt       = row_r;
    col_nxt       = col_r;
    func_nxt      = func_r;
    ch_nxt        = ch_r;
    rd_row_nxt    = rd_row_r;
    rd_col_nxt    = rd_col_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    case (uw.asel)
      tcw_pkg::AS_ZERO: a_nxt = '0;
      tcw_pkg::AS_INC:  a_nxt = a_r + 1'b1;
      default:          a_nxt = a_r;
    endcase

    case (uw.op)
      tcw_pkg::OP_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          func_nxt   = in_func;
          ch_nxt     = in_ch;
          rd_row_nxt = in_tdata[14:10];
          rd_col_nxt = in_tdata[21:15];
          cell_nxt   = '0;
        end
      end
      tcw_pkg::OP_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tcw_pkg::cell_addr(row_r, col_r);
        mem_wdata = {attr_r, ch_r};
        if (32'(col_r) == tcw_pkg::COLUMNS - 1) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      tcw_pkg::OP_NL: begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end
      tcw_pkg::OP_BS_RD: begin
        col_nxt   = col_r - 1'b1;
        mem_re    = 1'b1;
        mem_raddr = tcw_pkg::cell_addr(row_r, col_r - 1'b1);
      end
      tcw_pkg::OP_BS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = tcw_pkg::cell_addr(row_r, col_r);
        mem_wdata = {rd_q[15:8], tcw_pkg::BLANK_CHAR};
      end
      tcw_pkg::OP_RD: begin
        mem_re    = rd_in_range;
        mem_raddr = tcw_pkg::cell_addr(tcw_pkg::ROW_W'(rd_row_r), tcw_pkg::COL_W'(rd_col_r));
      end
      tcw_pkg::OP_RD_CAP: begin
        cell_nxt = rd_in_range ? rd_q : 16'd0;
      end
      tcw_pkg::OP_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      tcw_pkg::OP_FILL: begin
        mem_we = 1'b1;
      end
      tcw_pkg::OP_FILL_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      end
      tcw_pkg::OP_SCR_PRIME: begin
        // Fetch the first cell of row one; the copy loop then runs one behind.
        mem_re    = 1'b1;
        mem_raddr = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        row_nxt   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      end
      tcw_pkg::OP_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        mem_re    = (32'(a_r) != tcw_pkg::COPY_LAST);
        mem_raddr = a_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS + 1);
      end
      tcw_pkg::OP_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, cell_r[15:8], cell_r[7:0], 7'(col_r), 5'(row_r)};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= tcw_pkg::ST_INIT;
      a_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      a_r         <= a_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    ch_r       <= ch_nxt;
    rd_row_r   <= rd_row_nxt;
    rd_col_r   <= rd_col_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= screen_mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
